// ===== sv/ltl_pkg.sv =====
// ----------------------------------------------------------------------------
// Lambda term lexer package
// Shared types and constants for the lambda term lexer: the transaction
// structs of both channels, token and mode codes, and character codes.
// ----------------------------------------------------------------------------
package ltl_pkg;

    localparam longint MAX_SOURCE_BYTES = 65536;

    localparam int POS_W   = $clog2(MAX_SOURCE_BYTES + 1);
    localparam int START_W = 16;
    localparam int LEN_W   = 17;

    localparam longint START_CAP_VAL =
        (MAX_SOURCE_BYTES - 1 > 65535) ? 65535 : MAX_SOURCE_BYTES - 1;
    localparam longint LEN_CAP_VAL =
        (MAX_SOURCE_BYTES > 65536) ? 65536 : MAX_SOURCE_BYTES;

    localparam int MAX_RESULTS = 3;
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
    localparam int SLOT_W      = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_USCORE = 8'h5F;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_WS   = 2'd1,
        MODE_NAME = 2'd2,
        MODE_FAIL = 2'd3
    } lex_mode_t;

    typedef enum logic [3:0] {
        TK_OPEN   = 4'd0,
        TK_CLOSE  = 4'd1,
        TK_LSTART = 4'd2,
        TK_LEND   = 4'd3,
        TK_NL     = 4'd4,
        TK_WS     = 4'd5,
        TK_NAME   = 4'd6,
        TK_END    = 4'd7,
        TK_ERROR  = 4'd8
    } token_kind_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       final_byte;
    } lex_in_t;

    typedef struct packed {
        token_kind_t        token_kind;
        logic [START_W-1:0] start_pos;
        logic [LEN_W-1:0]   token_length;
        logic               last_of_source;
    } lex_out_t;

endpackage

// ===== sv/lambda_term_lexer_core.sv =====
// ----------------------------------------------------------------------------
// Lambda term lexer core: one source byte in per cycle while src_stall is low,
// tokens out of a queue; a token is registered into the queue when its byte is
// accepted and reaches the output behind any tokens queued before it. A byte that
// yields two or three tokens sends them in turn on the single output port (four-entry queue).
// Reset: asynchronous; clears the mode, position, open run and the queue.
// ----------------------------------------------------------------------------
module lambda_term_lexer_core
    import ltl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    output logic     src_stall,
    input  lex_in_t  src_data,
    output logic     tok_valid,
    input  logic     tok_stall,
    output lex_out_t tok_data
);

    localparam logic [POS_W-1:0]   POS_MAX   = POS_W'(MAX_SOURCE_BYTES);
    localparam logic [START_W-1:0] START_CAP = START_W'(START_CAP_VAL);
    localparam logic [LEN_W-1:0]   LEN_CAP   = LEN_W'(LEN_CAP_VAL);
    localparam logic [CNT_W-1:0]   ROOM_MAX  = CNT_W'(FIFO_DEPTH - MAX_RESULTS);

    lex_mode_t          mode_reg,  mode_next;
    logic [POS_W-1:0]   pos_reg,   pos_next;
    logic [START_W-1:0] start_reg, start_next;
    logic [LEN_W-1:0]   len_reg,   len_next;

    lex_out_t           fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;

    lex_out_t           slot [MAX_RESULTS];
    logic [SLOT_W-1:0]  slot_count;

    logic               accept;
    logic               pop;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A))
            || (c == CH_USCORE);
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_alpha(c) || ((c >= 8'h30) && (c <= 8'h39));
    endfunction

    function automatic logic [START_W-1:0] cap_start(input logic [POS_W-1:0] p);
        logic [POS_W:0] p_ext;
        p_ext = {1'b0, p};
        if (p_ext > (POS_W + 1)'(START_CAP))
            return START_CAP;
        return START_W'(p);
    endfunction

    function automatic lex_out_t make_tok(input token_kind_t kind,
                                          input logic [START_W-1:0] start,
                                          input logic [LEN_W-1:0] len,
                                          input logic last);
        lex_out_t t;
        t.token_kind     = kind;
        t.start_pos      = start;
        t.token_length   = len;
        t.last_of_source = last;
        return t;
    endfunction

    assign accept    = src_valid && !src_stall;
    assign pop       = tok_valid && !tok_stall;
    assign src_stall = (count_reg > ROOM_MAX);
    assign tok_valid = (count_reg != '0);
    assign tok_data  = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        logic [7:0]       b;
        logic             fin;
        lex_mode_t        run_mode;
        logic             single;
        token_kind_t      single_kind;
        logic [POS_W-1:0] pos_inc;

        b           = src_data.byte_value;
        fin         = src_data.final_byte;
        run_mode    = mode_reg;
        single      = 1'b1;
        single_kind = TK_OPEN;
        pos_inc     = (pos_reg < POS_MAX) ? pos_reg + POS_W'(1) : pos_reg;

        mode_next   = mode_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        slot_count  = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            slot[i] = '0;
        end

        unique case (b)
            CH_LPAREN: single_kind = TK_OPEN;
            CH_RPAREN: single_kind = TK_CLOSE;
            CH_BSLASH: single_kind = TK_LSTART;
            CH_DOT:    single_kind = TK_LEND;
            CH_LF:     single_kind = TK_NL;
            default:   single      = 1'b0;
        endcase

        if (mode_reg == MODE_FAIL)
        begin
            if (fin)
            begin
                slot[0]    = make_tok(TK_ERROR, start_reg, '0, 1'b1);
                slot_count = SLOT_W'(1);
                mode_next  = MODE_IDLE;
                pos_next   = '0;
                start_next = '0;
                len_next   = '0;
            end
        end
        else
        begin
            if (mode_reg == MODE_WS && !is_blank(b))
            begin
                slot[slot_count] = make_tok(TK_WS, start_reg, len_reg, 1'b0);
                slot_count       = slot_count + SLOT_W'(1);
                run_mode         = MODE_IDLE;
            end
            else if (mode_reg == MODE_NAME && !is_ident(b))
            begin
                slot[slot_count] = make_tok(TK_NAME, start_reg, len_reg, 1'b0);
                slot_count       = slot_count + SLOT_W'(1);
                run_mode         = MODE_IDLE;
            end
            mode_next = run_mode;

            if (run_mode == MODE_WS || run_mode == MODE_NAME)
            begin
                len_next = (len_reg < LEN_CAP) ? len_reg + LEN_W'(1) : len_reg;
            end
            else if (single)
            begin
                slot[slot_count] = make_tok(single_kind, cap_start(pos_reg),
                                            LEN_W'(1), 1'b0);
                slot_count       = slot_count + SLOT_W'(1);
            end
            else if (is_blank(b))
            begin
                mode_next  = MODE_WS;
                start_next = cap_start(pos_reg);
                len_next   = LEN_W'(1);
            end
            else if (is_alpha(b))
            begin
                mode_next  = MODE_NAME;
                start_next = cap_start(pos_reg);
                len_next   = LEN_W'(1);
            end
            else
            begin
                mode_next  = MODE_FAIL;
                start_next = cap_start(pos_reg);
                len_next   = '0;
            end

            if (mode_next == MODE_FAIL)
            begin
                slot[slot_count] = make_tok(TK_ERROR, cap_start(pos_reg), '0, fin);
                slot_count       = slot_count + SLOT_W'(1);
                if (fin)
                begin
                    mode_next  = MODE_IDLE;
                    pos_next   = '0;
                    start_next = '0;
                    len_next   = '0;
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end
            else
            begin
                pos_next = pos_inc;
                if (fin)
                begin
                    if (mode_next == MODE_WS)
                    begin
                        slot[slot_count] = make_tok(TK_WS, start_next, len_next, 1'b0);
                        slot_count       = slot_count + SLOT_W'(1);
                    end
                    else if (mode_next == MODE_NAME)
                    begin
                        slot[slot_count] = make_tok(TK_NAME, start_next, len_next, 1'b0);
                        slot_count       = slot_count + SLOT_W'(1);
                    end
                    slot[slot_count] = make_tok(TK_END, cap_start(pos_inc), '0, 1'b1);
                    slot_count       = slot_count + SLOT_W'(1);
                    mode_next  = MODE_IDLE;
                    pos_next   = '0;
                    start_next = '0;
                    len_next   = '0;
                end
            end
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(slot_count);
            count_next  = count_next + CNT_W'(slot_count);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
            count_next  = count_next - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            start_reg  <= '0;
            len_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg  <= mode_next;
                pos_reg   <= pos_next;
                start_reg <= start_next;
                len_reg   <= len_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                if (SLOT_W'(i) < slot_count)
                begin
                    fifo_reg[PTR_W'(wr_ptr_reg + PTR_W'(i))] <= slot[i];
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("token queue holds more transactions than its depth");

    a_source_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && src_data.final_byte |=> mode_reg == MODE_IDLE && pos_reg == '0)
        else $error("lexer state not cleared after the last byte of a source");

    a_fail_no_run: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_FAIL |-> len_reg == '0)
        else $error("open run length kept in the failed mode");

    a_pop_moves_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> rd_ptr_reg == $past(rd_ptr_reg) + PTR_W'(1))
        else $error("read pointer did not advance after a token transaction");
`endif

endmodule
